// ----- design/dqsr_pkg.sv -----
// ----------------------------------------------------------------------------
// dqsr_pkg
// Shared types and constants of the DQPSK symbol clock recovery block.
// ----------------------------------------------------------------------------
package dqsr_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int NOMINAL_W   = 16;
	localparam int GAIN_W      = 12;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 16'd4096;

	typedef enum logic [1:0] {
		SYM_POS_I = 2'd0,
		SYM_POS_Q = 2'd1,
		SYM_NEG_Q = 2'd2,
		SYM_NEG_I = 2'd3
	} sym_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NOMINAL = 2'd0,
		CFG_PGAIN   = 2'd1,
		CFG_IGAIN   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        [NOMINAL_W-1:0] nominal;
		logic signed [GAIN_W-1:0]    pgain;
		logic signed [GAIN_W-1:0]    igain;
	} cfg_t;

	typedef struct packed {
		logic valid;
		sym_t sym;
	} sym_beat_t;

endpackage

// ----- design/dqsr_top.sv -----
// ----------------------------------------------------------------------------
// dqpsk_symbol_clock_recovery
// DQPSK differential demodulator with a loop-tracked symbol clock.
// ----------------------------------------------------------------------------
// Samples enter on in_valid/in_ready with sample_i and sample_q; one sample
// per cycle is taken while the detector pipeline can move. Recovered symbols
// leave on out_valid/out_ready, at most one per symbol-clock wrap. Register
// writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. The user is to make writes only while the block is idle;
// the block itself does not enforce this. A sample that closes a symbol
// period shows its symbol on out_valid after three more detector stages, the
// queue and the loop stage. After every symbol-clock wrap the loop passes
// through a multiply state and a saturate state of the PI filter before it
// takes more symbols; the four-entry symbol queue keeps the detector running
// through those states.
// Reset clears the delay line fill state, the loop state and the queue, and
// loads the register defaults; the delay line reads as zero until DELAY
// samples have been taken. When out_ready is low the symbol is held, the loop
// stops taking symbols, the queue fills and then in_ready drops.
// ----------------------------------------------------------------------------
module dqpsk_symbol_clock_recovery
	import dqsr_pkg::*;
#(
	parameter int DELAY          = 32,
	parameter int COUNTER_BITS   = 16,
	parameter int ERROR_SUM_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 symbol,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cfg_t      cfg_q;
	sym_beat_t push;
	sym_beat_t head;
	logic      full;
	logic      pop;
	sym_t      sym_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nominal <= NOMINAL_RESET;
			cfg_q.pgain   <= '0;
			cfg_q.igain   <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NOMINAL: cfg_q.nominal <= cfg_data[NOMINAL_W-1:0];
				CFG_PGAIN:   cfg_q.pgain   <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_IGAIN:   cfg_q.igain   <= $signed(cfg_data[GAIN_W-1:0]);
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	dqsr_front #(
		.DELAY (DELAY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_i (sample_i),
		.sample_q (sample_q),
		.push     (push),
		.full     (full)
	);

	dqsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	dqsr_back #(
		.COUNTER_BITS   (COUNTER_BITS),
		.ERROR_SUM_BITS (ERROR_SUM_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (sym_out)
	);

	assign symbol = sym_out;

endmodule

// ----- design/dqsr_front.sv -----
// ----------------------------------------------------------------------------
// dqsr_front
// Differential detector: delay line, conjugate product and quadrant decision.
// ----------------------------------------------------------------------------
module dqsr_front
	import dqsr_pkg::*;
#(
	parameter int DELAY = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_i,
	input  logic signed [SAMPLE_W-1:0] sample_q,
	output sym_beat_t                  push,
	input  logic                       full
);

	localparam int PTR_W  = (DELAY > 1) ? $clog2(DELAY) : 1;
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int SUM_W  = PROD_W + 1;

	logic [2*SAMPLE_W-1:0] mem [DELAY];
	logic [PTR_W-1:0]      ptr_q;
	logic                  filled_q;
	logic                  en;
	logic                  take;

	logic                       v_s1, v_s2, v_s3, v_s4;
	logic signed [SAMPLE_W-1:0] si_s1, sq_s1;
	logic [2*SAMPLE_W-1:0]      rd_s1;
	logic                       dz_s1;
	logic signed [SAMPLE_W-1:0] di, dq;
	logic signed [PROD_W-1:0]   pii_s2, pqq_s2, pqi_s2, piq_s2;
	logic signed [SUM_W-1:0]    re_s3, im_s3;
	logic [SUM_W-1:0]           mre_s4, mim_s4;
	logic                       nre_s4, nim_s4;
	sym_t                       sym;

	assign en       = !v_s4 || !full;
	assign in_ready = en;
	assign take     = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			filled_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (take) begin
				if (ptr_q == PTR_W'(DELAY - 1)) begin
					ptr_q    <= '0;
					filled_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + PTR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1      <= mem[ptr_q];
			mem[ptr_q] <= {sample_i, sample_q};
			si_s1      <= sample_i;
			sq_s1      <= sample_q;
			dz_s1      <= !filled_q;
		end
	end

	assign di = dz_s1 ? '0 : $signed(rd_s1[2*SAMPLE_W-1:SAMPLE_W]);
	assign dq = dz_s1 ? '0 : $signed(rd_s1[SAMPLE_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			pii_s2 <= si_s1 * di;
			pqq_s2 <= sq_s1 * dq;
			pqi_s2 <= sq_s1 * di;
			piq_s2 <= si_s1 * dq;
			re_s3  <= SUM_W'(pii_s2) + SUM_W'(pqq_s2);
			im_s3  <= SUM_W'(pqi_s2) - SUM_W'(piq_s2);
			nre_s4 <= re_s3[SUM_W-1];
			nim_s4 <= im_s3[SUM_W-1];
			mre_s4 <= re_s3[SUM_W-1] ? SUM_W'(-re_s3) : SUM_W'(re_s3);
			mim_s4 <= im_s3[SUM_W-1] ? SUM_W'(-im_s3) : SUM_W'(im_s3);
		end
	end

	always_comb begin
		if (mre_s4 >= mim_s4) begin
			sym = nre_s4 ? SYM_NEG_I : SYM_POS_I;
		end else begin
			sym = nim_s4 ? SYM_NEG_Q : SYM_POS_Q;
		end
	end

	assign push.valid = v_s4 && !full;
	assign push.sym   = sym;

endmodule

// ----- design/dqsr_queue.sv -----
// ----------------------------------------------------------------------------
// dqsr_queue
// Short symbol queue between the detector and the timing loop.
// ----------------------------------------------------------------------------
module dqsr_queue
	import dqsr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sym_beat_t push,
	output logic      full,
	output sym_beat_t head,
	input  logic      pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sym_t             buf_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.sym   = buf_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			case ({push.valid, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			buf_q[wr_q] <= push.sym;
		end
	end

endmodule

// ----- design/dqsr_back.sv -----
// ----------------------------------------------------------------------------
// dqsr_back
// Symbol clock loop: phase accumulator, toggle tracking and PI loop filter.
// ----------------------------------------------------------------------------
module dqsr_back
	import dqsr_pkg::*;
#(
	parameter int COUNTER_BITS   = 16,
	parameter int ERROR_SUM_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  sym_beat_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output sym_t      symbol
);

	localparam int CB    = COUNTER_BITS;
	localparam int ESB   = ERROR_SUM_BITS;
	localparam int ERR_W = CB + 1;
	localparam int ACC_W = (ESB > ERR_W) ? ESB : ERR_W;
	localparam int PP_W  = ERR_W + GAIN_W;
	localparam int PI_W  = ESB + GAIN_W;
	localparam int MX_W  = (PP_W > PI_W) ? PP_W : PI_W;
	localparam int SX_W  = ((MX_W > 32) ? MX_W : 32) + 1;

	localparam logic signed [ERR_W-1:0] HALF   = ERR_W'(1) << (CB - 1);
	localparam logic signed [SX_W-1:0]  SAT_HI = SX_W'(64'sd2147483647);
	localparam logic signed [SX_W-1:0]  SAT_LO = SX_W'(-64'sd2147483648);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_MUL,
		ST_SUM
	} state_t;

	state_t                  state_q;
	sym_t                    last_q;
	logic [CB-1:0]           phase_q;
	logic [CB-1:0]           tphase_q;
	logic [1:0]              tcount_q;
	logic signed [ESB-1:0]   integ_q;
	logic signed [ERR_W-1:0] err_q;
	logic [CB-1:0]           corr_q;
	logic                    out_valid_q;
	sym_t                    symbol_q;

	logic signed [PP_W-1:0] prod_p_q;
	logic signed [PI_W-1:0] prod_i_q;

	logic                    toggle;
	logic [CB-1:0]           tphase_n;
	logic [1:0]              tcount_n;
	logic [CB-1:0]           phase_n;
	logic                    wrap;
	logic signed [ERR_W-1:0] err;
	logic signed [ACC_W-1:0] integ_sum;
	logic signed [SX_W-1:0]  corr_sum;
	logic [CB-1:0]           corr_sat;

	assign pop = (state_q == ST_RUN) && head.valid && (!out_valid_q || out_ready);

	assign toggle   = head.sym != last_q;
	assign tphase_n = toggle ? phase_q : tphase_q;
	assign tcount_n = (toggle && tcount_q != 2'd2) ? tcount_q + 2'd1 : tcount_q;
	assign phase_n  = phase_q + CB'(cfg.nominal) + corr_q;
	assign wrap     = phase_n < phase_q;
	assign err      = (tcount_n == 2'd1) ? HALF - $signed({1'b0, tphase_n}) : '0;
	assign integ_sum = ACC_W'(integ_q) + ACC_W'(err);

	assign corr_sum = SX_W'(prod_p_q) + SX_W'(prod_i_q);

	always_comb begin
		if (corr_sum > SAT_HI) begin
			corr_sat = '1;
		end else if (corr_sum < SAT_LO) begin
			corr_sat = '0;
		end else begin
			corr_sat = corr_sum[CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			last_q      <= SYM_POS_I;
			phase_q     <= '0;
			tphase_q    <= '0;
			tcount_q    <= '0;
			integ_q     <= '0;
			err_q       <= '0;
			corr_q      <= '0;
			out_valid_q <= 1'b0;
			symbol_q    <= SYM_POS_I;
		end else begin
			if (pop && wrap) begin
				out_valid_q <= 1'b1;
				symbol_q    <= head.sym;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						last_q   <= head.sym;
						phase_q  <= phase_n;
						tphase_q <= tphase_n;
						corr_q   <= '0;
						if (wrap) begin
							tcount_q <= '0;
							err_q    <= err;
							integ_q  <= integ_sum[ESB-1:0];
							state_q  <= ST_MUL;
						end else begin
							tcount_q <= tcount_n;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					corr_q  <= corr_sat;
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_p_q <= err_q * cfg.pgain;
			prod_i_q <= integ_q * cfg.igain;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DQPSK symbol clock recovery block.
// ----------------------------------------------------------------------------
// A fixed table of held IQ values walks the decision through every quadrant,
// the zero product, a magnitude tie and the sample extremes, with symbols that
// follow directly from the values. Random QPSK-like segments of about one
// symbol period (with noise and raw samples mixed in) then drive the symbol
// clock loop under several register settings. Every accepted sample runs
// through a local copy of the demodulator and loop, and every symbol transfer
// is compared with the oldest symbol due.
// ----------------------------------------------------------------------------
module tb_top
	import dqsr_pkg::*;
();

	localparam int DELAY_LEN = 32;
	localparam int PHASE_W   = 16;
	localparam int ERR_W     = 16;
	localparam int SETTLE_CYCLES = 16;
	localparam int unsigned RUN_LIMIT = 400000;

	typedef struct {
		int   si;
		int   sq;
		int   reps;
		bit   chk;
		sym_t sym;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_i;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [1:0]                 symbol;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	int send_gap;
	int recv_gap;
	int bad_count = 0;
	int unsigned cycle_count = 0;
	sym_t symbols_due[$];

	// demodulator and loop state
	int     dl_i[DELAY_LEN];
	int     dl_q[DELAY_LEN];
	int     dl_pos;
	sym_t   prev_sym;
	longint clk_phase;
	longint toggle_at;
	int     toggle_cnt;
	longint err_sum;
	longint loop_adj;
	longint nom_step;
	longint gain_p;
	longint gain_i;

	// rows line up with the 16-sample symbol period at reset, and the delay
	// spans two rows, so each row is decided against the row two back
	stim_row_t dir_rows[11] = '{
		'{ 32767, -32768, 16, 1'b1, SYM_POS_I},
		'{-32768,  32767, 16, 1'b1, SYM_POS_I},
		'{ 32767, -32768, 16, 1'b1, SYM_POS_I},
		'{-32768, -32768, 16, 1'b1, SYM_POS_Q},
		'{-32768,  32767, 16, 1'b1, SYM_NEG_I},
		'{-32767,  32767, 16, 1'b1, SYM_NEG_Q},
		'{     0,      0, 16, 1'b1, SYM_POS_I},
		'{     1,      0, 16, 1'b1, SYM_NEG_I},
		'{ 12345, -23456,  7, 1'b0, SYM_POS_I},
		'{    -1,      1,  9, 1'b0, SYM_POS_I},
		'{-32768,      0,  5, 1'b0, SYM_POS_I}
	};

	dqpsk_symbol_clock_recovery #(
		.DELAY         (DELAY_LEN),
		.COUNTER_BITS  (PHASE_W),
		.ERROR_SUM_BITS(ERR_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_i (sample_i),
		.sample_q (sample_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.symbol   (symbol),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_ready <= ($urandom_range(99) >= recv_gap);
	end

	always @(posedge clk) begin : check_symbols
		sym_t want;
		if (arst_n && out_valid && out_ready) begin
			if (symbols_due.size() == 0) begin
				$display("%0t: symbol with none due: expected none actual %0d", $time, symbol);
				bad_count++;
			end else begin
				want = symbols_due.pop_front();
				if (symbol !== want) begin
					$display("%0t: symbol: expected %0d actual %0d", $time, want, symbol);
					bad_count++;
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= RUN_LIMIT);
		$display("dqpsk_symbol_clock_recovery: mismatch");
		$finish;
	end

	function automatic int clip16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic recover_symbol(input int si, input int sq, output bit emit, output sym_t s);
		longint di, dq, re, im, mag_re, mag_im, nxt, err, corr, wrapped;
		sym_t d;
		di = dl_i[dl_pos];
		dq = dl_q[dl_pos];
		re = si * di + sq * dq;
		im = sq * di - si * dq;
		mag_re = (re < 0) ? -re : re;
		mag_im = (im < 0) ? -im : im;
		if (mag_re >= mag_im)
			d = (re >= 0) ? SYM_POS_I : SYM_NEG_I;
		else
			d = (im >= 0) ? SYM_POS_Q : SYM_NEG_Q;
		dl_i[dl_pos] = si;
		dl_q[dl_pos] = sq;
		dl_pos = (dl_pos + 1) % DELAY_LEN;
		if (d != prev_sym) begin
			toggle_at = clk_phase;
			if (toggle_cnt < 2)
				toggle_cnt++;
		end
		prev_sym = d;
		s = d;
		nxt = (clk_phase + nom_step + loop_adj) & ((longint'(1) << PHASE_W) - 1);
		loop_adj = 0;
		emit = (nxt < clk_phase);
		if (emit) begin
			err = (toggle_cnt == 1) ? (longint'(1) << (PHASE_W - 1)) - toggle_at : 0;
			wrapped = (err_sum + err) & ((longint'(1) << ERR_W) - 1);
			if (wrapped >= (longint'(1) << (ERR_W - 1)))
				wrapped -= longint'(1) << ERR_W;
			err_sum = wrapped;
			corr = err * gain_p + err_sum * gain_i;
			if (corr > 64'sd2147483647)
				corr = 64'sd2147483647;
			if (corr < -64'sd2147483648)
				corr = -64'sd2147483648;
			loop_adj = corr;
			toggle_cnt = 0;
		end
		clk_phase = nxt;
	endtask

	task automatic push_sample(input int si, input int sq, input bit chk, input sym_t want);
		bit emit;
		sym_t s;
		sym_t due;
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_i <= si[SAMPLE_W-1:0];
		sample_q <= sq[SAMPLE_W-1:0];
		do @(posedge clk); while (!in_ready);
		recover_symbol(si, sq, emit, s);
		if (emit) begin
			if (chk)
				due = want;
			else
				due = s;
			symbols_due = {symbols_due, due};
		end
	endtask

	// drop valid and hold until all symbols due are in, then let the pipe drain
	task automatic settle(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (symbols_due.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NOMINAL: nom_step = value;
			CFG_PGAIN:   gain_p = $signed(value[GAIN_W-1:0]);
			CFG_IGAIN:   gain_i = $signed(value[GAIN_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic program_regs(input int nom, input int pg, input int ig);
		write_reg(CFG_NOMINAL, nom[CFG_DATA_W-1:0]);
		write_reg(CFG_PGAIN, pg[CFG_DATA_W-1:0]);
		write_reg(CFG_IGAIN, ig[CFG_DATA_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_burst(input int count);
		int sent, seg_left, spb, amp, noise, rot, base_i, base_q, si, sq;
		bit raw, diag;
		sent = 0;
		seg_left = 0;
		raw = 1'b0;
		base_i = 0;
		base_q = 0;
		noise = 0;
		spb = (nom_step == 0) ? 16 : int'(65536 / nom_step);
		if (spb > 64)
			spb = 64;
		if (spb < 1)
			spb = 1;
		while (sent < count) begin
			if (seg_left == 0) begin
				raw = ($urandom_range(9) < 2);
				if (raw) begin
					seg_left = 1;
				end else begin
					seg_left = ($urandom_range(3) == 0) ? $urandom_range(48, 1)
						: spb + $urandom_range(4) - 2;
					if (seg_left < 1)
						seg_left = 1;
					amp = $urandom_range(32767, 1);
					noise = ($urandom_range(1) == 0) ? 0 : amp / 16;
					rot = $urandom_range(3);
					diag = $urandom_range(1);
					if (diag) begin
						base_i = (rot < 2) ? amp : -amp;
						base_q = (rot == 0 || rot == 3) ? amp : -amp;
					end else begin
						case (rot)
							0: begin base_i = amp;  base_q = 0;    end
							1: begin base_i = 0;    base_q = amp;  end
							2: begin base_i = -amp; base_q = 0;    end
							default: begin base_i = 0; base_q = -amp; end
						endcase
					end
				end
			end
			if (raw) begin
				si = int'($urandom_range(65535)) - 32768;
				sq = int'($urandom_range(65535)) - 32768;
			end else begin
				si = clip16(base_i + int'($urandom_range(2 * noise)) - noise);
				sq = clip16(base_q + int'($urandom_range(2 * noise)) - noise);
			end
			push_sample(si, sq, 1'b0, SYM_POS_I);
			seg_left--;
			sent++;
			if (sent == count / 2)
				settle(0);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_i = '0;
		sample_q = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NOMINAL;
		cfg_data = '0;
		send_gap = 21;
		recv_gap = 78;
		foreach (dl_i[k]) begin
			dl_i[k] = 0;
			dl_q[k] = 0;
		end
		dl_pos = 0;
		prev_sym = SYM_POS_I;
		clk_phase = 0;
		toggle_at = 0;
		toggle_cnt = 0;
		err_sum = 0;
		loop_adj = 0;
		nom_step = NOMINAL_RESET;
		gain_p = 0;
		gain_i = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			repeat (dir_rows[r].reps)
				push_sample(dir_rows[r].si, dir_rows[r].sq, dir_rows[r].chk, dir_rows[r].sym);
		random_burst(250);

		settle(SETTLE_CYCLES);
		program_regs(4096, 64, 8);
		random_burst(300);

		send_gap = 78;
		recv_gap = 21;
		settle(SETTLE_CYCLES);
		program_regs(65535, -1024, -1024);
		random_burst(250);

		settle(SETTLE_CYCLES);
		program_regs(0, 1024, 1024);
		random_burst(40);

		send_gap = 0;
		recv_gap = 0;
		settle(SETTLE_CYCLES);
		program_regs(3000, 200, 30);
		random_burst(300);

		settle(SETTLE_CYCLES);
		program_regs($urandom_range(9000, 2000), int'($urandom_range(2048)) - 1024,
			int'($urandom_range(2048)) - 1024);
		random_burst(300);

		settle(SETTLE_CYCLES);
		if (bad_count == 0)
			$display("dqpsk_symbol_clock_recovery: match");
		else
			$display("dqpsk_symbol_clock_recovery: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/dqsr_pkg.sv
design/dqsr_front.sv
design/dqsr_queue.sv
design/dqsr_back.sv
design/dqsr_top.sv
tb/tb_top.sv
